// ----- hdl/mpc_pkg.sv -----
// Shared constants and types for the minterm partition classifier.
`timescale 1ns / 1ps

package mpc_pkg;

  // Default sizes for the top-level parameters.
  localparam int SETS_DEF         = 32;
  localparam int CLASSES_DEF      = 64;
  localparam int ELEMENT_BITS_DEF = 16;

  // Fixed port widths.
  localparam int MEMBER_BITS   = 32;
  localparam int INDEX_BITS    = 16;
  localparam int CLASS_ID_BITS = 6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_WAIT,
    ST_RESOLVE
  } mpc_state_t;

  // Control part of the search token that walks the cell chain.
  typedef struct packed {
    logic valid;
    logic hit;
  } mpc_tok_t;

endpackage

// ----- hdl/minterm_partition_classifier_core.sv -----
// Top level: minterm classifier built from a chain of signature cells.
`timescale 1ns / 1ps

// Channel    | Signals                                          | Handshake
// -----------+--------------------------------------------------+------------------
// input      | run_start, element_index, membership             | in_valid/in_ready
// output     | element_id_out, in_union, class_id, new_class,   | out_valid/out_ready
//            | table_full                                       |
// config     | cfg_wdata (active_set_mask)                      | cfg_we, no wait
//
// Sequence: an element with a nonzero masked signature passes from its
//   transfer in through the launch state, then the wait state while the
//   search token walks the cell chain, then the resolve state, then idle,
//   where the next element is taken. An element outside the union goes to
//   resolve, then idle.
// Reset: rst clears the state machine, the class count, the mask and the
//   output valid. Stored signatures are not cleared; only cells below the
//   class count are ever compared.
// Stalls: the result sits in the output register; a new element is taken
//   while it waits. Only the resolve step waits for the output register.

module minterm_partition_classifier_core #(
  parameter int SETS         = mpc_pkg::SETS_DEF,
  parameter int CLASSES      = mpc_pkg::CLASSES_DEF,
  parameter int ELEMENT_BITS = mpc_pkg::ELEMENT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // config
  input  logic                              cfg_we,
  input  logic [mpc_pkg::MEMBER_BITS-1:0]   cfg_wdata,
  // input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              run_start,
  input  logic [mpc_pkg::INDEX_BITS-1:0]    element_index,
  input  logic [mpc_pkg::MEMBER_BITS-1:0]   membership,
  // output channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [mpc_pkg::INDEX_BITS-1:0]    element_id_out,
  output logic                              in_union,
  output logic [mpc_pkg::CLASS_ID_BITS-1:0] class_id,
  output logic                              new_class,
  output logic                              table_full
);

  import mpc_pkg::*;

  localparam int SIG_W  = (SETS < MEMBER_BITS) ? SETS : MEMBER_BITS;
  localparam int ELEM_W = (ELEMENT_BITS < INDEX_BITS) ? ELEMENT_BITS : INDEX_BITS;
  localparam int ID_W   = (CLASSES > 1) ? $clog2(CLASSES) : 1;
  localparam int CNT_W  = $clog2(CLASSES + 1);

  // configuration
  logic [MEMBER_BITS-1:0] active_set_mask;

  // element held during the search
  mpc_state_t        state, state_next;
  logic [SIG_W-1:0]  sig_r;
  logic [ELEM_W-1:0] elem_r;
  logic              union_r;
  logic              hit_r;
  logic [ID_W-1:0]   hit_id_r;
  logic [CNT_W-1:0]  count;

  logic              in_xfer;
  logic              out_free;
  logic              resolve_go;
  logic              tbl_wr;
  logic [SIG_W-1:0]  sig_in;

  // cell chain taps; tap k feeds cell k, tap CLASSES is the tail
  mpc_tok_t         tok_tap [0:CLASSES];
  logic [SIG_W-1:0] sig_tap [0:CLASSES];
  logic [ID_W-1:0]  id_tap  [0:CLASSES];

  assign sig_in     = membership[SIG_W-1:0] & active_set_mask[SIG_W-1:0];
  assign in_ready   = (state == ST_IDLE);
  assign in_xfer    = in_valid && in_ready;
  assign out_free   = !out_valid || out_ready;
  assign resolve_go = (state == ST_RESOLVE) && out_free;
  // a miss with room left stores the signature in the cell at the count
  assign tbl_wr     = resolve_go && union_r && !hit_r && (count < CNT_W'(CLASSES));

  always_ff @(posedge clk) begin
    if (rst) begin
      active_set_mask <= '0;
    end else if (cfg_we) begin
      active_set_mask <= cfg_wdata;
    end
  end

  // ---------------- control FSM ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          state_next = (sig_in != '0) ? ST_LAUNCH : ST_RESOLVE;
        end
      end
      ST_LAUNCH: begin
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (tok_tap[CLASSES].valid) begin
          state_next = ST_RESOLVE;
        end
      end
      ST_RESOLVE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // held element and search result
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      sig_r   <= sig_in;
      elem_r  <= element_index[ELEM_W-1:0];
      union_r <= (sig_in != '0);
      hit_r   <= 1'b0;
    end else if ((state == ST_WAIT) && tok_tap[CLASSES].valid) begin
      hit_r    <= tok_tap[CLASSES].hit;
      hit_id_r <= id_tap[CLASSES];
    end
  end

  // class count: a run start empties the table before the search
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (in_xfer && run_start) begin
      count <= '0;
    end else if (tbl_wr) begin
      count <= count + CNT_W'(1);
    end
  end

  // ---------------- cell chain ----------------
  assign tok_tap[0].valid = (state == ST_LAUNCH);
  assign tok_tap[0].hit   = 1'b0;
  assign sig_tap[0]       = sig_r;
  assign id_tap[0]        = '0;

  for (genvar k = 0; k < CLASSES; k++) begin : g_cell
    logic cell_live;
    logic cell_wr;

    assign cell_live = (CNT_W'(k) < count);
    assign cell_wr   = tbl_wr && (count == CNT_W'(k));

    mpc_cell #(
      .SIG_W (SIG_W),
      .ID_W  (ID_W),
      .INDEX (k)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .live    (cell_live),
      .wr_en   (cell_wr),
      .wr_sig  (sig_r),
      .tok_in  (tok_tap[k]),
      .sig_in  (sig_tap[k]),
      .id_in   (id_tap[k]),
      .tok_out (tok_tap[k+1]),
      .sig_out (sig_tap[k+1]),
      .id_out  (id_tap[k+1])
    );
  end

  // ---------------- output register ----------------
  logic [ID_W+CLASS_ID_BITS-1:0]  hit_id_ext;
  logic [CNT_W+CLASS_ID_BITS-1:0] count_ext;
  logic [ELEM_W+INDEX_BITS-1:0]   elem_ext;

  assign hit_id_ext = {{CLASS_ID_BITS{1'b0}}, hit_id_r};
  assign count_ext  = {{CLASS_ID_BITS{1'b0}}, count};
  assign elem_ext   = {{INDEX_BITS{1'b0}}, elem_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (resolve_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (resolve_go) begin
      element_id_out <= elem_ext[INDEX_BITS-1:0];
      in_union       <= union_r;
      class_id       <= '0;
      new_class      <= 1'b0;
      table_full     <= 1'b0;
      if (union_r) begin
        if (hit_r) begin
          class_id <= hit_id_ext[CLASS_ID_BITS-1:0];
        end else if (tbl_wr) begin
          class_id  <= count_ext[CLASS_ID_BITS-1:0];
          new_class <= 1'b1;
        end else begin
          table_full <= 1'b1;
        end
      end
    end
  end

  // ---------------- assertions ----------------
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CLASSES))
    else $error("class count past table size");

  a_tail_in_wait: assert property (@(posedge clk) disable iff (rst)
    tok_tap[CLASSES].valid |-> (state == ST_WAIT))
    else $error("search token left the chain outside the wait state");

  a_tail_sig: assert property (@(posedge clk) disable iff (rst)
    tok_tap[CLASSES].valid |-> (sig_tap[CLASSES] == sig_r))
    else $error("signature at chain tail differs from held element");

  a_out_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(new_class && table_full))
    else $error("new class and table full together");

  a_no_union: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !in_union) |-> (class_id == '0 && !new_class && !table_full))
    else $error("class reported for element outside the union");

  a_write_count: assert property (@(posedge clk) disable iff (rst)
    tbl_wr |=> (count == $past(count) + CNT_W'(1)))
    else $error("table write without count step");

endmodule

// ----- hdl/mpc_cell.sv -----
// One class cell: holds a stored signature and checks the passing search token.
`timescale 1ns / 1ps

module mpc_cell #(
  parameter int SIG_W = 32,
  parameter int ID_W  = 6,
  parameter int INDEX = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               live,
  input  logic               wr_en,
  input  logic [SIG_W-1:0]   wr_sig,
  input  mpc_pkg::mpc_tok_t  tok_in,
  input  logic [SIG_W-1:0]   sig_in,
  input  logic [ID_W-1:0]    id_in,
  output mpc_pkg::mpc_tok_t  tok_out,
  output logic [SIG_W-1:0]   sig_out,
  output logic [ID_W-1:0]    id_out
);

  import mpc_pkg::*;

  logic [SIG_W-1:0] stored;
  logic             match;

  // first live match wins; later cells leave an earlier hit alone
  assign match = live && !tok_in.hit && (stored == sig_in);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      stored <= wr_sig;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out.valid <= tok_in.valid;
      tok_out.hit   <= tok_in.hit || match;
    end
  end

  always_ff @(posedge clk) begin
    sig_out <= sig_in;
    id_out  <= match ? ID_W'(INDEX) : id_in;
  end

endmodule
